### design/csv_tok_pkg.sv
// Shared types, codes and helpers for the CSV line tokenizer.
package csv_tok_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned CfgAddrW  = 2;
    localparam int unsigned QDepth    = 4;
    localparam int unsigned QPtrW     = 2;
    localparam int unsigned QCntW     = 3;

    localparam logic [ByteW-1:0] DelimReset  = 8'd44;
    localparam logic [ByteW-1:0] QuoteReset  = 8'd34;
    localparam logic [ByteW-1:0] EscapeReset = 8'd92;
    localparam logic [ByteW-1:0] EolByte     = 8'd0;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_DELIM  = 2'd0,
        CFG_QUOTE  = 2'd1,
        CFG_ESCAPE = 2'd2
    } cfg_addr_t;

    typedef enum logic [2:0] {
        ST_START  = 3'd0,
        ST_NORMAL = 3'd1,
        ST_QUOTED = 3'd2,
        ST_ESC    = 3'd3,
        ST_CLOSE  = 3'd4,
        ST_ERROR  = 3'd5
    } scan_state_t;

    typedef enum logic [2:0] {
        CL_EOL    = 3'd0,
        CL_DELIM  = 3'd1,
        CL_QUOTE  = 3'd2,
        CL_ESCAPE = 3'd3,
        CL_TEXT   = 3'd4
    } byte_class_t;

    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_FEND = 2'd1,
        K_LEND = 2'd2,
        K_ERR  = 2'd3
    } kind_t;

    typedef struct packed {
        logic             field_is_null;
        kind_t            kind;
        logic [ByteW-1:0] data_byte;
        logic             last;
    } res_t;

    // Results of one byte: count (0..2), up to two results, next state.
    typedef struct packed {
        logic [1:0]  cnt;
        res_t        res0;
        res_t        res1;
        scan_state_t next_state;
    } step_t;

    function automatic res_t make_res(kind_t k, logic [ByteW-1:0] d, logic nul);
        res_t r;
        r.field_is_null = nul;
        r.kind          = k;
        r.data_byte     = d;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

### design/csv_tok_step.sv
// Per-byte scan logic: classifies the byte and computes results and next state.
module csv_tok_step (
    input  csv_tok_pkg::scan_state_t    state,
    input  logic [csv_tok_pkg::ByteW-1:0] char_byte,
    input  logic [csv_tok_pkg::ByteW-1:0] delimiter_byte,
    input  logic [csv_tok_pkg::ByteW-1:0] quote_byte,
    input  logic [csv_tok_pkg::ByteW-1:0] escape_byte,
    output csv_tok_pkg::step_t          step
);
    import csv_tok_pkg::*;

    byte_class_t cls;
    logic        doubled;
    logic        err;
    logic        is_null;

    always_comb
    begin
        if (char_byte == EolByte)
            cls = CL_EOL;
        else if (char_byte == delimiter_byte)
            cls = CL_DELIM;
        else if (char_byte == quote_byte)
            cls = CL_QUOTE;
        else if (char_byte == escape_byte)
            cls = CL_ESCAPE;
        else
            cls = CL_TEXT;
    end

    assign doubled = (quote_byte == escape_byte);
    assign is_null = (state == ST_START);

    always_comb
    begin
        step.cnt        = 2'd0;
        step.res0       = make_res(K_DATA, '0, 1'b0);
        step.res1       = make_res(K_DATA, '0, 1'b0);
        step.next_state = state;
        err             = 1'b0;

        unique case (state)
            ST_START, ST_NORMAL:
            begin
                if (cls == CL_TEXT)
                begin
                    step.cnt        = 2'd1;
                    step.res0       = make_res(K_DATA, char_byte, 1'b0);
                    step.next_state = ST_NORMAL;
                end
                else if (cls == CL_DELIM)
                begin
                    step.cnt        = 2'd1;
                    step.res0       = make_res(K_FEND, '0, is_null);
                    step.next_state = ST_START;
                end
                else if (cls == CL_EOL)
                begin
                    step.cnt        = 2'd2;
                    step.res0       = make_res(K_FEND, '0, is_null);
                    step.res1       = make_res(K_LEND, '0, 1'b0);
                    step.next_state = ST_START;
                end
                else if (cls == CL_QUOTE && state == ST_START)
                    step.next_state = ST_QUOTED;
                else
                    err = 1'b1;
            end
            ST_QUOTED:
            begin
                if (cls == CL_TEXT || cls == CL_DELIM)
                begin
                    step.cnt  = 2'd1;
                    step.res0 = make_res(K_DATA, char_byte, 1'b0);
                end
                else if (cls == CL_QUOTE)
                    step.next_state = ST_CLOSE;
                else if (cls == CL_ESCAPE)
                    step.next_state = ST_ESC;
                else
                    err = 1'b1;
            end
            ST_ESC:
            begin
                if (cls == CL_QUOTE)
                begin
                    step.cnt        = 2'd1;
                    step.res0       = make_res(K_DATA, char_byte, 1'b0);
                    step.next_state = ST_QUOTED;
                end
                else
                    err = 1'b1;
            end
            ST_CLOSE:
            begin
                if (cls == CL_QUOTE && doubled)
                begin
                    step.cnt        = 2'd1;
                    step.res0       = make_res(K_DATA, char_byte, 1'b0);
                    step.next_state = ST_QUOTED;
                end
                else if (cls == CL_DELIM)
                begin
                    step.cnt        = 2'd1;
                    step.res0       = make_res(K_FEND, '0, 1'b0);
                    step.next_state = ST_START;
                end
                else if (cls == CL_EOL)
                begin
                    step.cnt        = 2'd2;
                    step.res0       = make_res(K_FEND, '0, 1'b0);
                    step.res1       = make_res(K_LEND, '0, 1'b0);
                    step.next_state = ST_START;
                end
                else
                    err = 1'b1;
            end
            default:
            begin
                // skipping after an error; zero byte restarts silently
                step.next_state = (cls == CL_EOL) ? ST_START : ST_ERROR;
            end
        endcase

        if (err)
        begin
            step.cnt        = 2'd1;
            step.res0       = make_res(K_ERR, '0, 1'b0);
            step.res1       = make_res(K_DATA, '0, 1'b0);
            step.next_state = (cls == CL_EOL) ? ST_START : ST_ERROR;
        end

        // mark the final result of this byte
        if (step.cnt == 2'd2)
            step.res1.last = 1'b1;
        else if (step.cnt == 2'd1)
            step.res0.last = 1'b1;
    end

endmodule

### design/csv_tok_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one.
module csv_tok_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push_en,
    input  csv_tok_pkg::step_t              step,
    input  logic                            pop,
    output csv_tok_pkg::res_t               head,
    output logic [csv_tok_pkg::QCntW-1:0]   level
);
    import csv_tok_pkg::*;

    res_t             entry_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_next;
    logic [QCntW-1:0] count_reg;
    logic [QCntW-1:0] count_next;
    logic [1:0]       push_cnt;

    assign push_cnt    = push_en ? step.cnt : 2'd0;
    assign wr_ptr_next = wr_ptr_reg + QPtrW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + QPtrW'(pop);
    assign count_next  = count_reg + QCntW'(push_cnt) - QCntW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            entry_reg[wr_ptr_reg] <= step.res0;
        if (push_cnt == 2'd2)
            entry_reg[wr_ptr_reg + QPtrW'(1)] <= step.res1;
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign level = count_reg;

endmodule

### design/csv_line_tokenizer.sv
// CSV line tokenizer top level: input register, scan logic, result queue.
// Flow: an accepted byte waits in the input register and is scanned there; its results
//   go into the result queue, whose head drives the master side.
// Throughput: one byte per cycle while at most two results wait in the queue;
//   a line end gives two results, which leave the queue one at a time.
// Reset (rst_n, async low): scan state to start of field, queue empty,
//   delimiter 44, quote 34, escape 92.
module csv_line_tokenizer (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic [csv_tok_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [csv_tok_pkg::ByteW-1:0]     cfg_wdata,
    // byte input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] char_byte
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [7:0] data_byte
    output logic [2:0]                        m_axis_tuser,  // [1:0] kind, [2] field_is_null
    output logic                              m_axis_tlast
);
    import csv_tok_pkg::*;

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
    logic [ByteW-1:0] delimiter_reg;
    logic [ByteW-1:0] quote_reg;
    logic [ByteW-1:0] escape_reg;

    // Input register holding the next byte to scan.
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [ByteW-1:0] in_byte_reg;

    scan_state_t      state_reg;
    scan_state_t      state_next;

    step_t            step;
    res_t             head;
    logic [QCntW-1:0] level;
    logic             take;
    logic             advance;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DelimReset;
            quote_reg     <= QuoteReset;
            escape_reg    <= EscapeReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DELIM:  delimiter_reg <= cfg_wdata;
                CFG_QUOTE:  quote_reg     <= cfg_wdata;
                CFG_ESCAPE: escape_reg    <= cfg_wdata;
                default:    ;  // unused index, write dropped
            endcase
        end
    end

    // A byte is scanned once the queue has room for two results, the worst case.
    assign advance       = in_valid_reg && (level <= QCntW'(QDepth - 2));
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= s_axis_tdata;
    end

    csv_tok_step u_step (
        .state          (state_reg),
        .char_byte      (in_byte_reg),
        .delimiter_byte (delimiter_reg),
        .quote_byte     (quote_reg),
        .escape_byte    (escape_reg),
        .step           (step)
    );

    assign state_next = advance ? step.next_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_START;
        else
            state_reg <= state_next;
    end

    assign pop = m_axis_tvalid && m_axis_tready;

    csv_tok_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (advance),
        .step    (step),
        .pop     (pop),
        .head    (head),
        .level   (level)
    );

    assign m_axis_tvalid = (level != '0);
    assign m_axis_tdata  = head.data_byte;
    assign m_axis_tuser  = {head.field_is_null, head.kind};
    assign m_axis_tlast  = head.last;

`ifndef NO_ASSERTIONS
    // Queue never overflows its four slots.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QCntW'(QDepth))
        else $error("result queue overflow");

    // While skipping after an error no result is produced.
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg == ST_ERROR) |-> (step.cnt == 2'd0))
        else $error("result produced while skipping");

    // An empty queue always lets a new byte in.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty queue");

    // A held byte that was not scanned stays put.
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending byte lost");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the CSV line tokenizer: directed and random lines, scoreboard.
module tb;
    import csv_tok_pkg::*;

    // Register index past the three real registers; the block must ignore it.
    localparam logic [CfgAddrW-1:0] CfgSpare = 2'd3;

    localparam int LongHold      = 120;   // receiver hold-off, enough to back up the input
    localparam int HoldEvery     = 400;   // one long hold-off per this many results
    localparam int SettleCycles  = 4;     // margin after the scoreboard empties
    localparam int TailCycles    = 12;
    localparam int WatchdogLimit = 2000;  // cycles with no handshake on either side
    localparam int ItemsPerPhase = 250;

    // Directed requests, default registers: delimiter 0x2C, quote 0x22, escape 0x5C.
    localparam logic [7:0] DirectedSeq [29] = '{
        8'h00,                                                  // empty line
        8'hFF, 8'h01, 8'h2C, 8'h2C, 8'h22, 8'h2C, 8'h5C, 8'h22, 8'h22, 8'h00,
                                                                // text, null field, quoted
        8'h61, 8'h22, 8'h00,                                    // quote in unquoted, skip
        8'h5C, 8'h00,                                           // escape outside quotes
        8'h22, 8'h5C, 8'h61, 8'h00,                             // escape not before quote
        8'h22, 8'h5C, 8'h00,                                    // escape before end of line
        8'h22, 8'h00,                                           // unterminated quote
        8'h22, 8'h22, 8'h61, 8'h00                              // text after closing quote
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr = '0;
    logic [ByteW-1:0]    cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // [7:0] char_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;        // [7:0] data_byte
    logic [2:0]          m_axis_tuser;        // [1:0] kind, [2] field_is_null
    logic                m_axis_tlast;

    csv_line_tokenizer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow of the block: registers and scanner state.
    logic [7:0]  delim_reg  = DelimReset;
    logic [7:0]  quote_reg  = QuoteReset;
    logic [7:0]  escape_reg = EscapeReset;
    scan_state_t scan_st    = ST_START;

    logic [7:0] pending_bytes [$];    // requests not yet offered
    res_t       expected_tokens [$];  // tokens predicted, not yet seen
    int         bytes_queued = 0;
    int         send_gap_max = 11;
    int         recv_gap_max = 11;
    int         send_gap = 0;
    int         recv_stall = 0;
    int         next_stall;
    int         tokens_seen = 0;
    int         errors = 0;
    int         quiet_cycles = 0;
    res_t       exp_tok;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic void add_token(input kind_t k, input logic [7:0] d, input logic nul);
        res_t t;
        t.kind          = k;
        t.data_byte     = d;
        t.field_is_null = nul;
        t.last          = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    // Scanner prediction for one accepted byte; appends its tokens to the scoreboard.
    function automatic void tokenize_byte(input logic [7:0] b);
        byte_class_t cls;
        logic        fault;
        logic        nul;
        int          first;
        res_t        t;
        first = expected_tokens.size();
        fault = 1'b0;
        nul   = (scan_st == ST_START);
        // class priority: end of line, delimiter, quote, escape, text
        if (b == EolByte)         cls = CL_EOL;
        else if (b == delim_reg)  cls = CL_DELIM;
        else if (b == quote_reg)  cls = CL_QUOTE;
        else if (b == escape_reg) cls = CL_ESCAPE;
        else                      cls = CL_TEXT;
        case (scan_st)
            ST_START, ST_NORMAL:
            begin
                if (cls == CL_TEXT)
                begin
                    add_token(K_DATA, b, 1'b0);
                    scan_st = ST_NORMAL;
                end
                else if (cls == CL_DELIM)
                begin
                    add_token(K_FEND, 8'h00, nul);
                    scan_st = ST_START;
                end
                else if (cls == CL_EOL)
                begin
                    add_token(K_FEND, 8'h00, nul);
                    add_token(K_LEND, 8'h00, 1'b0);
                    scan_st = ST_START;
                end
                else if (cls == CL_QUOTE && scan_st == ST_START)
                    scan_st = ST_QUOTED;
                else
                    fault = 1'b1;
            end
            ST_QUOTED:
            begin
                // delimiters are plain content inside quotes
                if (cls == CL_TEXT || cls == CL_DELIM)
                    add_token(K_DATA, b, 1'b0);
                else if (cls == CL_QUOTE)
                    scan_st = ST_CLOSE;
                else if (cls == CL_ESCAPE)
                    scan_st = ST_ESC;
                else
                    fault = 1'b1;
            end
            ST_ESC:
            begin
                if (cls == CL_QUOTE)
                begin
                    add_token(K_DATA, b, 1'b0);
                    scan_st = ST_QUOTED;
                end
                else
                    fault = 1'b1;
            end
            ST_CLOSE:
            begin
                // doubled-quote mode: a second quote is literal content
                if (cls == CL_QUOTE && quote_reg == escape_reg)
                begin
                    add_token(K_DATA, b, 1'b0);
                    scan_st = ST_QUOTED;
                end
                else if (cls == CL_DELIM)
                begin
                    add_token(K_FEND, 8'h00, 1'b0);
                    scan_st = ST_START;
                end
                else if (cls == CL_EOL)
                begin
                    add_token(K_FEND, 8'h00, 1'b0);
                    add_token(K_LEND, 8'h00, 1'b0);
                    scan_st = ST_START;
                end
                else
                    fault = 1'b1;
            end
            default:
                // skipping after an error: silent until end of line
                scan_st = (cls == CL_EOL) ? ST_START : ST_ERROR;
        endcase
        // every error path fires before any token was added for this byte
        if (fault)
        begin
            add_token(K_ERR, 8'h00, 1'b0);
            scan_st = (cls == CL_EOL) ? ST_START : ST_ERROR;
        end
        if (expected_tokens.size() > first)
        begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.insert(expected_tokens.size(), t);
        end
    endfunction

    // Driver: offers pending requests with a random gap drawn per request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                tokenize_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    s_axis_tdata  <= pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= $urandom_range(0, send_gap_max);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each token against the oldest prediction, then draws
    // its own stall. Every HoldEvery tokens it holds off long so the block's
    // result queue fills and the input side backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end
        else
        begin
            next_stall = recv_stall;
            if (m_axis_tvalid && m_axis_tready)
            begin
                tokens_seen++;
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token: kind %0d data %0h",
                           m_axis_tuser[1:0], m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_tok = expected_tokens.pop_front();
                    if (m_axis_tuser[1:0] !== exp_tok.kind)
                    begin
                        $error("kind: expected %0d, actual %0d",
                               exp_tok.kind, m_axis_tuser[1:0]);
                        errors++;
                    end
                    if (m_axis_tdata !== exp_tok.data_byte)
                    begin
                        $error("data_byte: expected %0h, actual %0h",
                               exp_tok.data_byte, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser[2] !== exp_tok.field_is_null)
                    begin
                        $error("field_is_null: expected %0b, actual %0b",
                               exp_tok.field_is_null, m_axis_tuser[2]);
                        errors++;
                    end
                    if (m_axis_tlast !== exp_tok.last)
                    begin
                        $error("last: expected %0b, actual %0b",
                               exp_tok.last, m_axis_tlast);
                        errors++;
                    end
                end
                next_stall = (tokens_seen % HoldEvery == 0) ? LongHold
                                                            : $urandom_range(0, recv_gap_max);
            end
            if (next_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_stall    <= next_stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_stall    <= 0;
            end
        end
    end

    // Watchdog: a run that stops moving on both sides is a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WatchdogLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] text_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(1, 255));
        while (v == delim_reg || v == quote_reg || v == escape_reg);
        return v;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
        bytes_queued++;
    endfunction

    // Drives a register write from the next rising edge on; the caller lowers cfg_we.
    task automatic set_register(input logic [CfgAddrW-1:0] idx, input logic [7:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_DELIM:  delim_reg  = v;
            CFG_QUOTE:  quote_reg  = v;
            CFG_ESCAPE: escape_reg = v;
            default:    ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] d, input logic [7:0] q, input logic [7:0] e);
        set_register(CFG_DELIM, d);
        set_register(CFG_QUOTE, q);
        set_register(CFG_ESCAPE, e);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until all requests are sent and every predicted token is back, then let the
    // pipeline settle (bytes that open a quote leave no token behind).
    task automatic drain();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // One line of random fields under the current registers. A broken line
    // gets one byte replaced by a special byte or a random one.
    task automatic queue_line(input bit broken);
        logic [7:0] line_bytes [$];
        int         nfields;
        int         pick;
        int         pos;
        nfields = $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 1)
                repeat ($urandom_range(1, 6)) line_bytes = {line_bytes, text_byte()};
            else if (pick >= 2)
            begin
                line_bytes = {line_bytes, quote_reg};
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 3))
                        0: line_bytes = {line_bytes, delim_reg};
                        1:
                        begin
                            // escaped quote; a doubled quote when escape == quote
                            line_bytes = {line_bytes, escape_reg};
                            line_bytes = {line_bytes, quote_reg};
                        end
                        default: line_bytes = {line_bytes, text_byte()};
                    endcase
                end
                line_bytes = {line_bytes, quote_reg};
            end
            line_bytes = {line_bytes, ((f == nfields - 1) ? EolByte : delim_reg)};
        end
        if (broken && line_bytes.size() > 1)
        begin
            pos = $urandom_range(0, line_bytes.size() - 2);
            case ($urandom_range(0, 3))
                0: line_bytes[pos] = quote_reg;
                1: line_bytes[pos] = escape_reg;
                2: line_bytes[pos] = EolByte;
                default: line_bytes[pos] = 8'($urandom_range(0, 255));
            endcase
        end
        foreach (line_bytes[i]) push_byte(line_bytes[i]);
    endtask

    // Noise: specials mixed with arbitrary bytes, closed by an end of line.
    task automatic queue_noise();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 4))
                0: push_byte(EolByte);
                1: push_byte(delim_reg);
                2: push_byte(quote_reg);
                3: push_byte(escape_reg);
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
        push_byte(EolByte);
    endtask

    task automatic run_random_phase(input int n, input logic [7:0] d, input logic [7:0] q,
                                    input logic [7:0] e, input int smax, input int rmax);
        int start;
        int pick;
        drain();
        apply_setting(d, q, e);
        send_gap_max = smax;
        recv_gap_max = rmax;
        start = bytes_queued;
        while (bytes_queued - start < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                queue_line(1'b0);
            else if (pick < 9)
                queue_line(1'b1);
            else
                queue_noise();
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // spare index first: 0xFF must stay plain text afterwards
        set_register(CfgSpare, 8'hFF);
        apply_setting(DelimReset, QuoteReset, EscapeReset);
        foreach (DirectedSeq[i]) push_byte(DirectedSeq[i]);

        // default registers, no idling on either side
        run_random_phase(ItemsPerPhase, DelimReset, QuoteReset, EscapeReset, 0, 0);
        // doubled-quote mode; phase ends inside an open quoted field so the
        // next setting takes effect mid-line
        run_random_phase(ItemsPerPhase, DelimReset, QuoteReset, QuoteReset, 11, 11);
        push_byte(quote_reg);
        push_byte(text_byte());
        // extreme register values
        run_random_phase(ItemsPerPhase, 8'd1, 8'd255, 8'd254, 3, 11);
        run_random_phase(ItemsPerPhase, 8'd255, 8'd1, 8'd1, 11, 0);
        // delimiter shadows the quote: no quoted field can open
        run_random_phase(ItemsPerPhase, 8'd9, 8'd9, EscapeReset, 11, 11);
        // random registers, half of the time in doubled-quote mode
        begin
            logic [7:0] rd;
            logic [7:0] rq;
            logic [7:0] re;
            rd = 8'($urandom_range(1, 255));
            rq = 8'($urandom_range(1, 255));
            re = $urandom_range(0, 1) ? rq : 8'($urandom_range(1, 255));
            run_random_phase(ItemsPerPhase, rd, rq, re, 11, 3);
        end

        drain();
        repeat (TailCycles) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
